// File: sv/qsd_pkg.sv
// ============================================================================
// qsd_pkg
// Shared types for the descending quicksort block.
// ============================================================================
`default_nettype none

package qsd_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] value_t;

endpackage

`default_nettype wire

// File: sv/qsd_if.sv
// ============================================================================
// qsd_in_if / qsd_out_if
// Valid/ready channels for loaded elements and sorted results.
// ============================================================================
`default_nettype none

interface qsd_in_if;
  import qsd_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  logic   is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

interface qsd_out_if;
  import qsd_pkg::*;

  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   end_of_set;
  logic   overflow;

  modport source (output valid, output sorted_value, output end_of_set, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input end_of_set, input overflow,
                output ready);
endinterface

`default_nettype wire

// File: sv/qsd_ram.sv
// ============================================================================
// qsd_ram
// Simple dual-port RAM: one write port, one registered read port.
// ============================================================================
`default_nettype none

module qsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/qsd_sorter.sv
// ============================================================================
// qsd_sorter
// Hole-partition quicksort sequencer with an explicit range stack.
// ============================================================================
`default_nettype none

module qsd_sorter #(
  parameter int MAX_ELEMS = 64,
  localparam int IW = $clog2(MAX_ELEMS),
  localparam int CW = $clog2(MAX_ELEMS + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [CW-1:0]  count,
  output logic                done,
  output logic                el_we,
  output logic [IW-1:0]       el_waddr,
  output qsd_pkg::value_t     el_wdata,
  output logic [IW-1:0]       el_raddr,
  input  wire qsd_pkg::value_t el_rdata
);
  import qsd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_POPW  = 3'd2;
  localparam logic [2:0] S_PIV   = 3'd3;
  localparam logic [2:0] S_HCMP  = 3'd4;
  localparam logic [2:0] S_LCMP  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_PUSH2 = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IW-1:0] lo0_r, lo0_nxt, hi0_r, hi0_nxt;
  value_t        pivot_r, pivot_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic          done_r, done_nxt;

  logic [IW-1:0]   lo_inc, hi_dec;
  logic [CW-1:0]   sp_m1;
  logic            st_we;
  logic [IW-1:0]   st_waddr, st_raddr;
  logic [2*IW-1:0] st_wdata, st_rdata;

  function automatic logic [IW-1:0] lo_inc_mid(input logic [IW-1:0] mid);
    return mid + 1'b1;
  endfunction

  assign lo_inc = lo_r + 1'b1;
  assign hi_dec = hi_r - 1'b1;
  assign sp_m1  = sp_r - 1'b1;
  assign done   = done_r;

  qsd_ram #(.WIDTH(2*IW), .DEPTH(MAX_ELEMS)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    lo0_nxt   = lo0_r;
    hi0_nxt   = hi0_r;
    pivot_nxt = pivot_r;
    sp_nxt    = sp_r;
    done_nxt  = 1'b0;
    el_we     = 1'b0;
    el_waddr  = lo_r;
    el_wdata  = el_rdata;
    el_raddr  = lo_r;
    st_we     = 1'b0;
    st_waddr  = sp_r[IW-1:0];
    st_wdata  = {lo0_r, hi_dec};
    st_raddr  = sp_m1[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (count >= CW'(2)) begin
            st_we     = 1'b1;
            st_waddr  = '0;
            st_wdata  = {{IW{1'b0}}, IW'(count - 1'b1)};
            sp_nxt    = CW'(1);
            state_nxt = S_POP;
          end else begin
            done_nxt = 1'b1;
          end
        end
      end
      S_POP: begin
        sp_nxt    = sp_m1;
        state_nxt = S_POPW;
      end
      S_POPW: begin
        lo_nxt    = st_rdata[2*IW-1:IW];
        hi_nxt    = st_rdata[IW-1:0];
        lo0_nxt   = st_rdata[2*IW-1:IW];
        hi0_nxt   = st_rdata[IW-1:0];
        el_raddr  = st_rdata[2*IW-1:IW];
        state_nxt = S_PIV;
      end
      S_PIV: begin
        pivot_nxt = el_rdata;
        el_raddr  = hi_r;
        state_nxt = S_HCMP;
      end
      S_HCMP: begin
        if (pivot_r >= el_rdata) begin
          hi_nxt    = hi_dec;
          el_raddr  = hi_dec;
          state_nxt = (lo_r < hi_dec) ? S_HCMP : S_FIN;
        end else begin
          // fill the hole at the low end, the hole moves to hi
          el_we     = 1'b1;
          el_waddr  = lo_r;
          lo_nxt    = lo_inc;
          el_raddr  = lo_inc;
          state_nxt = (lo_inc < hi_r) ? S_LCMP : S_FIN;
        end
      end
      S_LCMP: begin
        if (el_rdata >= pivot_r) begin
          lo_nxt    = lo_inc;
          el_raddr  = lo_inc;
          state_nxt = (lo_inc < hi_r) ? S_LCMP : S_FIN;
        end else begin
          el_we     = 1'b1;
          el_waddr  = hi_r;
          hi_nxt    = hi_dec;
          el_raddr  = hi_dec;
          state_nxt = (lo_r < hi_dec) ? S_HCMP : S_FIN;
        end
      end
      S_FIN: begin
        el_we    = 1'b1;
        el_waddr = hi_r;
        el_wdata = pivot_r;
        if ({1'b0, hi_r} > ({1'b0, lo0_r} + 1'b1)) begin
          st_we  = 1'b1;
          sp_nxt = sp_r + 1'b1;
        end
        state_nxt = S_PUSH2;
      end
      S_PUSH2: begin
        st_wdata = {lo_inc_mid(hi_r), hi0_r};
        if (({1'b0, hi_r} + 1'b1) < {1'b0, hi0_r}) begin
          st_we  = 1'b1;
          sp_nxt = sp_r + 1'b1;
        end
        if (sp_nxt == '0) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_POP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      done_r  <= done_nxt;
    end
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    lo0_r   <= lo0_nxt;
    hi0_r   <= hi0_nxt;
    pivot_r <= pivot_nxt;
  end

  // Pending ranges are disjoint and hold two or more elements each.
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CW'(MAX_ELEMS / 2))
    else $error("range stack deeper than half the store");

  // Scanning keeps both ends inside the popped range.
  a_scan_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HCMP || state_r == S_LCMP) |->
      (lo_r < hi_r && lo0_r <= lo_r && hi_r <= hi0_r))
    else $error("partition scan left its range");

  // A finished sort leaves the stack empty.
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (sp_r == '0 && state_r == S_IDLE))
    else $error("sort reported done with ranges pending");

endmodule

`default_nettype wire

// File: sv/quicksort_descending.sv
// ============================================================================
// quicksort_descending
// Loads a set of signed values, sorts it by quicksort, emits it largest first.
// ============================================================================
// Load: one item per cycle; an item without is_last gives no result.
// Sort: each partition pops a range, reads its pivot, scans the range from both ends,
//   writes the pivot into the hole and pushes sub-ranges of two or more elements; the
//   pace is set by the single compare unit and the one read port of the element store.
// Emit: results are read from the store and registered at the output, one result per cycle while the sink holds ready.
// Reset: synchronous, active low; clears count, drop flag and sequencers. The
//   element store and range stack need no clearing pass.
`default_nettype none

module quicksort_descending #(
  parameter int MAX_ELEMS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qsd_in_if.sink     in_ch,
  qsd_out_if.source  out_ch
);
  import qsd_pkg::*;

  localparam int IW = $clog2(MAX_ELEMS);
  localparam int CW = $clog2(MAX_ELEMS + 1);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;   // elements held for this set
  logic          dropped_r, dropped_nxt;
  logic [CW-1:0] emit_idx_r, emit_idx_nxt;

  // Emit path: read in flight, output register, skid register.
  logic   pend_r, pend_last_r;
  logic   out_valid_r, out_last_r;
  value_t out_data_r;
  logic   skid_valid_r, skid_last_r;
  value_t skid_data_r;

  logic          in_take, out_take, has_room, issue;
  logic [1:0]    occ;
  logic          sort_start, sort_done;

  // Element store port, shared by load, sorter and emit.
  logic          el_we;
  logic [IW-1:0] el_waddr, el_raddr;
  value_t        el_wdata, el_rdata;
  logic          s_we;
  logic [IW-1:0] s_waddr, s_raddr;
  value_t        s_wdata;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_take    = out_valid_r && out_ch.ready;
  assign has_room    = (count_r < CW'(MAX_ELEMS));

  // Start the sorter on the edge that takes the last item.
  assign sort_start  = in_take && in_ch.is_last;

  // Keep at most two items between read port and output.
  assign occ   = {1'b0, out_valid_r} + {1'b0, skid_valid_r} + {1'b0, pend_r};
  assign issue = (state_r == ST_EMIT) && (emit_idx_r < count_r)
                 && (occ <= (2'd1 + {1'b0, out_take}));

  qsd_sorter #(.MAX_ELEMS(MAX_ELEMS)) u_sorter (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sort_start),
    .count    (count_nxt),
    .done     (sort_done),
    .el_we    (s_we),
    .el_waddr (s_waddr),
    .el_wdata (s_wdata),
    .el_raddr (s_raddr),
    .el_rdata (el_rdata)
  );

  // Route the single store port by phase.
  always_comb begin
    el_we    = 1'b0;
    el_waddr = count_r[IW-1:0];
    el_wdata = in_ch.value;
    el_raddr = emit_idx_r[IW-1:0];
    unique case (state_r)
      ST_LOAD: el_we = in_take && has_room;
      ST_SORT: begin
        el_we    = s_we;
        el_waddr = s_waddr;
        el_wdata = s_wdata;
        el_raddr = s_raddr;
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  qsd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMS)) u_store (
    .clk   (clk),
    .we    (el_we),
    .waddr (el_waddr),
    .wdata (el_wdata),
    .raddr (el_raddr),
    .rdata (el_rdata)
  );

  // Top-level phase control.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    dropped_nxt  = dropped_r;
    emit_idx_nxt = emit_idx_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_take) begin
          // drop values past capacity, remember that we did
          if (has_room) begin
            count_nxt = count_r + 1'b1;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_ch.is_last) begin
            state_nxt = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        if (sort_done) begin
          emit_idx_nxt = '0;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (issue) begin
          emit_idx_nxt = emit_idx_r + 1'b1;
        end
        if (out_take && out_last_r) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          state_nxt   = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      dropped_r    <= 1'b0;
      emit_idx_r   <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      dropped_r  <= dropped_nxt;
      emit_idx_r <= emit_idx_nxt;
      pend_r     <= issue;
      // advance the output register from skid first, then from the read port
      if (!out_valid_r || out_take) begin
        out_valid_r <= skid_valid_r || pend_r;
        if (skid_valid_r) begin
          skid_valid_r <= pend_r;
        end
      end else if (pend_r) begin
        skid_valid_r <= 1'b1;
      end
    end
    pend_last_r <= ((emit_idx_r + 1'b1) == count_r);
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        out_last_r  <= skid_last_r;
        skid_data_r <= el_rdata;
        skid_last_r <= pend_last_r;
      end else begin
        out_data_r <= el_rdata;
        out_last_r <= pend_last_r;
      end
    end else if (pend_r) begin
      // hold the output, park the arriving item
      skid_data_r <= el_rdata;
      skid_last_r <= pend_last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_data_r;
  assign out_ch.end_of_set   = out_last_r;
  assign out_ch.overflow     = dropped_r;

  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("loading and emitting at once");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ELEMS))
    else $error("element count past capacity");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> (out_valid_r && !pend_r))
    else $error("skid register holds an item out of order");

  a_set_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_last_r) |-> (emit_idx_r == count_r && !skid_valid_r && !pend_r))
    else $error("end of set emitted with items left");

endmodule

`default_nettype wire
